// File: hw/rtl/tkfc_pkg.sv
// ----------------------------------------------------------------------------
// tkfc_pkg: shared types and constants
// Sizes, request codes and engine states of the TTL keyed cache.
// ----------------------------------------------------------------------------
`default_nettype none
package tkfc_pkg;

  localparam int unsigned Entries  = 64;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned CntW     = $clog2(Entries + 1);
  localparam int unsigned KeyW     = 64;
  localparam int unsigned TypeW    = 16;
  localparam int unsigned PayW     = 32;
  localparam int unsigned ExpW     = 33;
  localparam int unsigned EntryW   = KeyW + TypeW + PayW + ExpW;
  localparam int unsigned OutCntW  = 7;
  localparam logic [31:0] MinTtlStart = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ReqStore  = 2'd0,
    ReqLookup = 2'd1,
    ReqSweep  = 2'd2,
    ReqNone   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    StIdle,
    StScanRd,
    StScan,
    StDropRd,
    StDrop,
    StAppend,
    StReply
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TypeW-1:0] qtype;
    logic [PayW-1:0]  pay;
    logic [ExpW-1:0]  exp;
  } entry_t;

endpackage
`default_nettype wire

// File: hw/rtl/tkfc_ram.sv
// ----------------------------------------------------------------------------
// tkfc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module tkfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/tkfc_engine.sv
// ----------------------------------------------------------------------------
// tkfc_engine: request sequencer
// Walks the entry RAM one entry per cycle for lookup, compaction, drop-oldest
// and append; keeps count and running minimum TTL.
// ----------------------------------------------------------------------------
`default_nettype none
module tkfc_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request
  input  wire logic                         req_valid_i,
  output logic                              req_stall_o,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [31:0]                  now_seconds_i,
  input  wire logic [63:0]                  name_key_i,
  input  wire logic [15:0]                  query_type_i,
  input  wire logic [31:0]                  payload_handle_i,
  input  wire logic [31:0]                  record_ttl_i,
  input  wire logic                         record_valid_i,
  input  wire logic                         last_record_i,
  // RAM side
  output logic                              we_o,
  output logic [tkfc_pkg::IdxW-1:0]         waddr_o,
  output tkfc_pkg::entry_t                  wdata_o,
  output logic [tkfc_pkg::IdxW-1:0]         raddr_o,
  input  tkfc_pkg::entry_t                  rdata_i,
  // result
  output logic                              res_valid_o,
  input  wire logic                         res_stall_i,
  output logic                              op_done_o,
  output logic                              hit_o,
  output logic [31:0]                       hit_payload_o,
  output logic [6:0]                        entries_held_o,
  output logic                              dropped_oldest_o,
  output logic [6:0]                        expired_removed_o
);

  localparam int unsigned IdxW = tkfc_pkg::IdxW;
  localparam int unsigned CntW = tkfc_pkg::CntW;
  localparam logic [CntW-1:0] Full = CntW'(tkfc_pkg::Entries);

  tkfc_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [31:0]      min_q, min_d;
  logic [CntW-1:0]  rd_q, rd_d;     // read pointer
  logic [CntW-1:0]  kept_q, kept_d; // write pointer during compaction
  tkfc_pkg::req_e   req_q, req_d;
  logic [31:0]      now_q, now_d;
  tkfc_pkg::entry_t item_q, item_d; // key/type/payload of request; exp = now+min
  logic             hit_q, hit_d;
  logic [31:0]      hpay_q, hpay_d;
  logic             drop_q, drop_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic             done_q, done_d;
  logic             rv_q, rv_d;     // result register valid

  logic             accept;
  logic             live;
  logic             out_free;

  assign out_free    = !rv_q || !res_stall_i;
  assign req_stall_o = (state_q != tkfc_pkg::StIdle) || !out_free;
  assign accept      = req_valid_i && !req_stall_o;
  assign live        = rdata_i.exp > {1'b0, now_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tkfc_pkg::StIdle;
      count_q <= '0;
      min_q   <= tkfc_pkg::MinTtlStart;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      min_q   <= min_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q   <= rd_d;
    kept_q <= kept_d;
    req_q  <= req_d;
    now_q  <= now_d;
    item_q <= item_d;
    hit_q  <= hit_d;
    hpay_q <= hpay_d;
    drop_q <= drop_d;
    rem_q  <= rem_d;
    done_q <= done_d;
  end

  // next state and datapath
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    min_d   = min_q;
    rd_d    = rd_q;
    kept_d  = kept_q;
    req_d   = req_q;
    now_d   = now_q;
    item_d  = item_q;
    hit_d   = hit_q;
    hpay_d  = hpay_q;
    drop_d  = drop_q;
    rem_d   = rem_q;
    done_d  = done_q;
    rv_d    = rv_q && res_stall_i;
    we_o    = 1'b0;
    waddr_o = kept_q[IdxW-1:0];
    wdata_o = rdata_i;
    raddr_o = rd_q[IdxW-1:0];
    case (state_q)
      tkfc_pkg::StIdle: begin
        if (accept) begin
          req_d  = tkfc_pkg::req_e'(req_type_i);
          now_d  = now_seconds_i;
          item_d.key   = name_key_i;
          item_d.qtype = query_type_i;
          item_d.pay   = payload_handle_i;
          item_d.exp   = {1'b0, now_seconds_i} + {1'b0, min_q};
          hit_d  = 1'b0;
          hpay_d = '0;
          drop_d = 1'b0;
          rem_d  = '0;
          done_d = 1'b0;
          rd_d   = '0;
          kept_d = '0;
          raddr_o = '0;
          state_d = tkfc_pkg::StReply;
          case (tkfc_pkg::req_e'(req_type_i))
            tkfc_pkg::ReqStore: begin
              if (record_valid_i && record_ttl_i < min_q) begin
                min_d = record_ttl_i;
                item_d.exp = {1'b0, now_seconds_i} + {1'b0, record_ttl_i};
              end
              if (last_record_i) begin
                min_d  = tkfc_pkg::MinTtlStart;
                done_d = 1'b1;
                state_d = (count_q >= Full) ? tkfc_pkg::StScanRd
                                            : tkfc_pkg::StAppend;
              end
            end
            tkfc_pkg::ReqLookup: begin
              done_d  = 1'b1;
              state_d = (count_q != '0) ? tkfc_pkg::StScanRd : tkfc_pkg::StReply;
            end
            tkfc_pkg::ReqSweep: begin
              done_d  = 1'b1;
              state_d = (count_q != '0) ? tkfc_pkg::StScanRd : tkfc_pkg::StReply;
            end
            default: ;
          endcase
        end
      end
      // read issued for entry rd_q
      tkfc_pkg::StScanRd: begin
        raddr_o = rd_q[IdxW-1:0];
        rd_d    = rd_q + 1'b1;
        state_d = tkfc_pkg::StScan;
      end
      // rdata holds entry rd_q-1; next read already aimed at rd_q
      tkfc_pkg::StScan: begin
        raddr_o = rd_q[IdxW-1:0];
        if (req_q == tkfc_pkg::ReqLookup) begin
          if (live && rdata_i.key == item_q.key && rdata_i.qtype == item_q.qtype) begin
            hit_d   = 1'b1;
            hpay_d  = rdata_i.pay;
            state_d = tkfc_pkg::StReply;
          end else if (rd_q >= count_q) begin
            state_d = tkfc_pkg::StReply;
          end else begin
            rd_d = rd_q + 1'b1;
          end
        end else begin
          // compaction: live entries move down to kept_q
          if (live) begin
            we_o   = (kept_q != rd_q - 1'b1);
            kept_d = kept_q + 1'b1;
          end else begin
            rem_d = rem_q + 1'b1;
          end
          if (rd_q >= count_q) begin
            count_d = live ? kept_q + 1'b1 : kept_q;
            if (req_q == tkfc_pkg::ReqSweep) begin
              state_d = tkfc_pkg::StReply;
            end else if (live && kept_q + 1'b1 >= Full) begin
              drop_d  = 1'b1;
              rd_d    = CntW'(1);
              kept_d  = '0;
              state_d = tkfc_pkg::StDropRd;
            end else begin
              state_d = tkfc_pkg::StAppend;
            end
          end else begin
            rd_d = rd_q + 1'b1;
          end
        end
      end
      // drop oldest: shift entries 1..count-1 down one
      tkfc_pkg::StDropRd: begin
        raddr_o = rd_q[IdxW-1:0];
        rd_d    = rd_q + 1'b1;
        state_d = tkfc_pkg::StDrop;
      end
      tkfc_pkg::StDrop: begin
        raddr_o = rd_q[IdxW-1:0];
        we_o    = 1'b1;
        kept_d  = kept_q + 1'b1;
        if (rd_q >= count_q) begin
          count_d = count_q - 1'b1;
          state_d = tkfc_pkg::StAppend;
        end else begin
          rd_d = rd_q + 1'b1;
        end
      end
      tkfc_pkg::StAppend: begin
        we_o    = 1'b1;
        waddr_o = count_q[IdxW-1:0];
        wdata_o = item_q;
        count_d = count_q + 1'b1;
        state_d = tkfc_pkg::StReply;
      end
      tkfc_pkg::StReply: begin
        rv_d    = 1'b1;
        state_d = tkfc_pkg::StIdle;
      end
      default: state_d = tkfc_pkg::StIdle;
    endcase
  end

  assign res_valid_o       = rv_q;
  assign op_done_o         = done_q;
  assign hit_o             = hit_q;
  assign hit_payload_o     = hpay_q;
  assign entries_held_o    = 7'(count_q);
  assign dropped_oldest_o  = drop_q;
  assign expired_removed_o = 7'(rem_q);

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full) else $error("entry count above capacity");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tkfc_pkg::StIdle) |-> !accept) else $error("accept while busy");
  a_reply_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tkfc_pkg::StReply) |=> rv_q) else $error("result not raised");
  a_hit_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && hit_q) |-> (req_q == tkfc_pkg::ReqLookup)) else $error("hit off lookup");

endmodule
`default_nettype wire

// File: hw/rtl/ttl_keyed_fifo_cache_unit.sv
// ----------------------------------------------------------------------------
// ttl_keyed_fifo_cache_unit: TTL cache of DNS answers with FIFO eviction
// Ordered table in one entry RAM, scanned and compacted by a sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  request | req_valid_i/stall_o   | req_type_i .. last_record_i
//  result  | res_valid_o/stall_i   | op_done_o .. expired_removed_o
//
//  A last store record with room appends directly. Lookup scans until a hit
//  or the last entry, sweep scans all entries; both skip the scan when empty.
//  Full store: adds a compaction and, if still full, a drop-oldest shift.
//  Reset clears count and minimum TTL; entry RAM is not cleared.
//  A stalled result holds and the next item waits.
`default_nettype none
module ttl_keyed_fifo_cache_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] now_seconds_i,
  input  wire logic [63:0] name_key_i,
  input  wire logic [15:0] query_type_i,
  input  wire logic [31:0] payload_handle_i,
  input  wire logic [31:0] record_ttl_i,
  input  wire logic        record_valid_i,
  input  wire logic        last_record_i,
  output logic             res_valid_o,
  input  wire logic        res_stall_i,
  output logic             op_done_o,
  output logic             hit_o,
  output logic [31:0]      hit_payload_o,
  output logic [6:0]       entries_held_o,
  output logic             dropped_oldest_o,
  output logic [6:0]       expired_removed_o
);

  logic                        we;
  logic [tkfc_pkg::IdxW-1:0]   waddr, raddr;
  tkfc_pkg::entry_t            wdata, rdata;
  logic [tkfc_pkg::EntryW-1:0] rdata_raw;

  assign rdata = tkfc_pkg::entry_t'(rdata_raw);

  tkfc_ram #(
    .Width(tkfc_pkg::EntryW),
    .Depth(tkfc_pkg::Entries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  tkfc_engine u_engine (
    .clk_i, .rst_ni,
    .req_valid_i, .req_stall_o, .req_type_i, .now_seconds_i, .name_key_i,
    .query_type_i, .payload_handle_i, .record_ttl_i, .record_valid_i,
    .last_record_i,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr),
    .rdata_i(rdata),
    .res_valid_o, .res_stall_i, .op_done_o, .hit_o, .hit_payload_o,
    .entries_held_o, .dropped_oldest_o, .expired_removed_o
  );

endmodule
`default_nettype wire
